>>> rtl/dht_pkg.sv
// Package with shared types and codes for the double hashing key table.
package dht_pkg;

    // Command codes.
    localparam logic [1:0] CMD_SEARCH = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_REMOVED   = 3'd3;
    localparam logic [2:0] ST_RM_MISS   = 3'd4;
    localparam logic [2:0] ST_HIT       = 3'd5;
    localparam logic [2:0] ST_MISS      = 3'd6;

    // Configuration register indexes.
    localparam logic REG_TABLE_SIZE  = 1'b0;
    localparam logic REG_PROBE_PRIME = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_MOD,
        S_PROBE,
        S_WAIT,
        S_WRITE,
        S_OUT
    } state_t;

endpackage

>>> rtl/double_hash_table_top.sv
// Top level of the double hashing key table: sequencer, probe memories and counters.
// A command runs the remainder unit, then makes P probes, P at most S, the effective table size;
// the step is reduced R times before the first probe (only when prime >= S).
// One bit-serial remainder unit runs twice; each probe then passes the probe and wait states.
// One command at a time: no new command is taken until the result has been delivered.
// Reset: counters and configuration return to defaults, then a clearing pass empties every slot.
module double_hash_table_top
    import dht_pkg::*;
#(
    parameter int MAX_SLOTS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [30:0] key,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [9:0]  slot,
    output logic        slot_valid,
    output logic [15:0] insert_count,
    output logic [31:0] collision_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int CW = AW + 1;
    localparam int SW = (CW > 11) ? CW : 11;
    // Remainder and step width, wide enough for both the size and the prime.
    localparam int MW = (CW > 10) ? CW : 10;

    // Configuration registers.
    logic [10:0] table_size_reg;
    logic [9:0]  probe_prime_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg  <= 11'd1024;
            probe_prime_reg <= 10'd1021;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_TABLE_SIZE)
                table_size_reg <= cfg_data;
            else
                probe_prime_reg <= cfg_data[9:0];
        end
    end

    // Effective size and prime.
    logic [SW-1:0] size_ext;
    logic [CW-1:0] eff_size;
    logic [9:0]    eff_prime;
    assign size_ext  = SW'(table_size_reg);
    assign eff_size  = (table_size_reg == 11'd0) ? CW'(1) :
                       (size_ext > SW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(table_size_reg);
    assign eff_prime = (probe_prime_reg == 10'd0) ? 10'd1 : probe_prime_reg;

    // Sequencer registers.
    state_t        state_reg, state_next;
    logic [1:0]    cmd_reg;
    logic [30:0]   key_q_reg;
    logic [30:0]   rem_src_reg;
    logic [5:0]    bit_cnt_reg;
    logic [MW-1:0] rem_reg;
    logic          mod_phase_reg;
    logic [CW-1:0] addr_reg;
    logic [MW-1:0] step_reg;
    logic [CW:0]   probe_cnt_reg;
    logic          free_seen_reg;
    logic [AW-1:0] first_free_reg;
    logic [CW:0]   occ_reg;
    logic          hit_reg;
    logic [AW-1:0] hit_addr_reg;
    logic [15:0]   ins_reg;
    logic [31:0]   coll_reg;
    logic [2:0]    status_reg;
    logic [9:0]    slot_reg;
    logic          slot_valid_reg;
    logic [AW-1:0] clr_addr_reg;

    // Memories.
    logic          used_mem [MAX_SLOTS];
    logic [30:0]   key_mem  [MAX_SLOTS];
    logic          used_rd;
    logic [30:0]   key_rd;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_used;
    logic          wr_key;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            used_mem[wr_addr] <= wr_used;
            if (wr_key)
                key_mem[wr_addr] <= key_q_reg;
        end
        used_rd <= used_mem[rd_addr];
        key_rd  <= key_mem[rd_addr];
    end

    // Remainder step: shift in one key bit and subtract the modulus once when it fits.
    logic [MW-1:0] modulus;
    logic [MW+1:0] rem_shift;
    logic [MW+1:0] rem_sub;
    logic [MW-1:0] rem_next;
    assign modulus   = mod_phase_reg ? MW'(eff_prime) : MW'(eff_size);
    assign rem_shift = {1'b0, rem_reg, rem_src_reg[30]};
    assign rem_sub   = rem_shift - (MW+2)'(modulus);
    assign rem_next  = rem_sub[MW+1] ? rem_shift[MW-1:0] : rem_sub[MW-1:0];

    // Next probe address: (addr + step) mod size, both already below size.
    logic [CW:0] addr_sum;
    logic [CW:0] addr_wrap;
    assign addr_sum  = {1'b0, addr_reg} + (CW+1)'(step_reg);
    assign addr_wrap = (addr_sum >= (CW+1)'(eff_size)) ? addr_sum - (CW+1)'(eff_size)
                                                        : addr_sum;

    // Probe result evaluation.
    logic probe_hit;
    assign probe_hit = used_rd && (key_rd == key_q_reg);

    // Collision update.
    logic [32:0] coll_add;
    logic [31:0] coll_new;
    always_comb
    begin
        coll_add = {1'b0, coll_reg} + 33'(occ_reg);
        if (hit_reg)
        begin
            if (occ_reg == '0)
                coll_new = (coll_reg != 32'd0) ? coll_reg - 32'd1 : 32'd0;
            else
            begin
                coll_add = {1'b0, coll_reg} + 33'(occ_reg) - 33'd1;
                coll_new = coll_add[32] ? 32'hFFFF_FFFF : coll_add[31:0];
            end
        end
        else
            coll_new = coll_add[32] ? 32'hFFFF_FFFF : coll_add[31:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
                if (clr_addr_reg == AW'(MAX_SLOTS - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (in_valid && command != CMD_NONE)
                    state_next = S_MOD;
            S_MOD:
                if (bit_cnt_reg == 6'd30 && mod_phase_reg)
                    state_next = S_PROBE;
            S_PROBE:
                // Stay until the step has been reduced below the size.
                if (step_reg < MW'(eff_size))
                    state_next = S_WAIT;
            S_WAIT:
                if (probe_hit || probe_cnt_reg == (CW+1)'(eff_size) - (CW+1)'(1))
                    state_next = S_WRITE;
                else
                    state_next = S_PROBE;
            S_WRITE:
                state_next = S_OUT;
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Outputs and memory control.
    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
        rd_addr  = addr_reg[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = clr_addr_reg;
        wr_used  = 1'b0;
        wr_key   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
                wr_en = 1'b1;
            S_WRITE:
            begin
                if (cmd_reg == CMD_INSERT && !hit_reg && free_seen_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = first_free_reg;
                    wr_used = 1'b1;
                    wr_key  = 1'b1;
                end
                else if (cmd_reg == CMD_REMOVE && hit_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = hit_addr_reg;
                end
            end
            default:
                wr_en = 1'b0;
        endcase
    end

    // Sequencer datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            ins_reg      <= '0;
            coll_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_CLEAR:
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                S_IDLE:
                begin
                    cmd_reg       <= command;
                    key_q_reg     <= key;
                    rem_src_reg   <= key;
                    rem_reg       <= '0;
                    bit_cnt_reg   <= '0;
                    mod_phase_reg <= 1'b0;
                    probe_cnt_reg <= '0;
                    free_seen_reg <= 1'b0;
                    first_free_reg <= '0;
                    occ_reg       <= '0;
                    hit_reg       <= 1'b0;
                end
                S_MOD:
                begin
                    // One quotient bit per cycle; key mod size, then key mod prime.
                    rem_reg     <= rem_next;
                    rem_src_reg <= {rem_src_reg[29:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg + 6'd1;
                    if (bit_cnt_reg == 6'd30)
                    begin
                        bit_cnt_reg   <= '0;
                        rem_src_reg   <= key_q_reg;
                        rem_reg       <= '0;
                        mod_phase_reg <= 1'b1;
                        if (!mod_phase_reg)
                            addr_reg <= CW'(rem_next);
                        else
                            step_reg <= MW'(eff_prime) - rem_next;
                    end
                end
                S_PROBE:
                begin
                    // Step may reach or exceed the size when the prime is not below it.
                    if (step_reg >= MW'(eff_size))
                        step_reg <= step_reg - MW'(eff_size);
                end
                S_WAIT:
                begin
                    if (used_rd && !free_seen_reg)
                        occ_reg <= occ_reg + (CW+1)'(1);
                    if (probe_hit)
                    begin
                        hit_reg      <= 1'b1;
                        hit_addr_reg <= addr_reg[AW-1:0];
                    end
                    if (!used_rd && !free_seen_reg)
                    begin
                        free_seen_reg  <= 1'b1;
                        first_free_reg <= addr_reg[AW-1:0];
                    end
                    addr_reg      <= addr_wrap[CW-1:0];
                    probe_cnt_reg <= probe_cnt_reg + (CW+1)'(1);
                end
                S_WRITE:
                begin
                    slot_valid_reg <= hit_reg || free_seen_reg;
                    slot_reg       <= hit_reg ? 10'(hit_addr_reg) :
                                      free_seen_reg ? 10'(first_free_reg) : 10'd0;
                    if (cmd_reg != CMD_REMOVE)
                        coll_reg <= coll_new;
                    unique case (cmd_reg)
                        CMD_SEARCH:
                            status_reg <= hit_reg ? ST_HIT : ST_MISS;
                        CMD_INSERT:
                        begin
                            if (hit_reg)
                                status_reg <= ST_DUPLICATE;
                            else if (free_seen_reg)
                            begin
                                status_reg <= ST_INSERTED;
                                if (ins_reg != 16'hFFFF)
                                    ins_reg <= ins_reg + 16'd1;
                            end
                            else
                                status_reg <= ST_FULL;
                        end
                        default:
                            status_reg <= hit_reg ? ST_REMOVED : ST_RM_MISS;
                    endcase
                end
                default:
                    clr_addr_reg <= clr_addr_reg;
            endcase
        end
    end

    assign out_valid       = (state_reg == S_OUT);
    assign status          = status_reg;
    assign slot            = slot_reg;
    assign slot_valid      = slot_valid_reg;
    assign insert_count    = ins_reg;
    assign collision_total = coll_reg;

endmodule

>>> rtl/dht_checker.sv
// Port-level checker for the double hashing key table, bound to the top level.
module dht_checker
    import dht_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic        slot_valid,
    input logic [15:0] insert_count
);

    // The block never takes a command while a result waits.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("command accepted while result pending");

    // A held result keeps its status.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status))
        else $error("result changed while stalled");

    // Placement and hits always name a slot.
    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_INSERTED || status == ST_HIT || status == ST_REMOVED)
        |-> slot_valid)
        else $error("slot missing");

    // The insert counter never decreases.
    a_ins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> insert_count >= $past(insert_count))
        else $error("insert count fell");

endmodule

bind double_hash_table_top dht_checker u_dht_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .slot_valid   (slot_valid),
    .insert_count (insert_count)
);

>>> tb/sv/double_hash_table_checker.sv
// Checker for the double hashing key table: predicts every result and compares it.
module double_hash_table_checker
    import dht_pkg::*;
#(
    parameter int MAX_SLOTS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  command,
    input  logic [30:0] key,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [9:0]  slot,
    input  logic        slot_valid,
    input  logic [15:0] insert_count,
    input  logic [31:0] collision_total,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  slot;
        logic        slot_valid;
        logic [15:0] insert_count;
        logic [31:0] collision_total;
    } lookup_result_t;

    // Shadow copy of the table and its counters.
    bit          occupied [MAX_SLOTS];
    logic [30:0] stored_key [MAX_SLOTS];
    logic [15:0] inserts;
    logic [31:0] collisions;
    logic [10:0] size_reg;
    logic [9:0]  prime_reg;
    lookup_result_t expected_q [$];

    assign pending = expected_q.size();

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 result_count, what, got, want);
        fail_count++;
    endtask

    // Scan the probe sequence, update the shadow state and return the result.
    function automatic lookup_result_t predict_lookup(input logic [1:0] cmd,
                                                      input logic [30:0] k);
        lookup_result_t r;
        int unsigned size, prime, step, addr, first_free, occ;
        bit free_seen, hit;
        size = (size_reg == 0) ? 1 : (size_reg > MAX_SLOTS ? MAX_SLOTS : size_reg);
        prime = (prime_reg == 0) ? 1 : prime_reg;
        step = prime - (k % prime);
        addr = k % size;
        free_seen = 0;
        hit = 0;
        first_free = 0;
        occ = 0;
        for (int unsigned i = 0; i < size; i++)
        begin
            if (occupied[addr] && !free_seen)
                occ++;
            if (occupied[addr] && stored_key[addr] == k)
            begin
                hit = 1;
                first_free = addr;
                break;
            end
            if (!occupied[addr] && !free_seen)
            begin
                free_seen = 1;
                first_free = addr;
            end
            addr = (addr + step) % size;
        end
        // Collision total, saturating at both ends.
        if (cmd != CMD_REMOVE)
        begin
            if (hit && occ == 0)
            begin
                if (collisions > 0)
                    collisions--;
            end
            else
            begin
                if (hit)
                    occ--;
                if (64'(collisions) + occ > 64'hFFFF_FFFF)
                    collisions = 32'hFFFF_FFFF;
                else
                    collisions += occ;
            end
        end
        case (cmd)
            CMD_SEARCH: r.status = hit ? ST_HIT : ST_MISS;
            CMD_INSERT:
            begin
                if (hit)
                    r.status = ST_DUPLICATE;
                else if (free_seen)
                begin
                    occupied[first_free] = 1;
                    stored_key[first_free] = k;
                    if (inserts != 16'hFFFF)
                        inserts++;
                    r.status = ST_INSERTED;
                end
                else
                    r.status = ST_FULL;
            end
            default:
            begin
                if (hit)
                begin
                    occupied[first_free] = 0;
                    r.status = ST_REMOVED;
                end
                else
                    r.status = ST_RM_MISS;
            end
        endcase
        r.slot_valid = hit || free_seen;
        r.slot = r.slot_valid ? 10'(first_free) : 10'd0;
        r.insert_count = inserts;
        r.collision_total = collisions;
        return r;
    endfunction

    // Watch configuration writes, accepted commands and delivered results.
    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t want;
        if (!rst_n)
        begin
            foreach (occupied[i])
                occupied[i] = 0;
            inserts = 0;
            collisions = 0;
            size_reg = 11'd1024;
            prime_reg = 10'd1021;
            expected_q.delete();
            fail_count = 0;
            result_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TABLE_SIZE)
                    size_reg = cfg_data;
                else
                    prime_reg = cfg_data[9:0];
            end
            if (in_valid && in_ready && command != CMD_NONE)
                expected_q.push_back(predict_lookup(command, key));
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected transfer, status", status, -1);
                else
                begin
                    want = expected_q.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (slot !== want.slot)
                        report_mismatch("slot", slot, want.slot);
                    if (slot_valid !== want.slot_valid)
                        report_mismatch("slot_valid", slot_valid, want.slot_valid);
                    if (insert_count !== want.insert_count)
                        report_mismatch("insert_count", insert_count, want.insert_count);
                    if (collision_total !== want.collision_total)
                        report_mismatch("collision_total", collision_total,
                                        want.collision_total);
                end
                result_count++;
            end
        end
    end
endmodule

>>> tb/sv/double_hash_table_top_tb.sv
// Testbench top for the double hashing key table: stimulus, idling and verdict.
module double_hash_table_top_tb
    import dht_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [30:0] key;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [9:0]  slot;
    logic        slot_valid;
    logic [15:0] insert_count;
    logic [31:0] collision_total;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [10:0] cfg_data;
    int          fail_count;
    int          pending;
    int          result_count;

    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;
    int          hold_cycles;
    longint      cycle_count;
    logic [30:0] key_pool [$];

    localparam longint CYCLE_LIMIT = 64'd20_000_000;

    double_hash_table_top uut (.*);

    double_hash_table_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stalls plus an optional long hold-off.
    always @(negedge clk)
    begin
        if (hold_off)
        begin
            out_ready <= 0;
            hold_cycles++;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // One register write; valid is dropped again before the task returns.
    task automatic write_reg(input logic [0:0] idx, input logic [10:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    // Wait for every result, then a margin so the block is idle.
    task automatic drain_table;
        in_valid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (2200) @(negedge clk);
    endtask

    // Offer one command; valid stays high on return so transfers can follow back to back.
    task automatic send_command(input logic [1:0] cmd, input logic [30:0] k);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            command <= 2'($urandom);
            key <= 31'($urandom);
            @(negedge clk);
        end
        command <= cmd;
        key <= k;
        in_valid <= 1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Random key, mostly reusing keys already offered so hits and removes happen.
    function automatic logic [30:0] pick_key;
        logic [30:0] k;
        if (key_pool.size() != 0 && $urandom_range(99) < 60)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        case ($urandom_range(3))
            0: k = 31'($urandom_range(63));
            1: k = 31'h7FFF_FFFF - 31'($urandom_range(63));
            default: k = 31'($urandom);
        endcase
        key_pool.push_back(k);
        return k;
    endfunction

    task automatic random_phase(input int count);
        int r;
        logic [1:0] cmd;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            cmd = (r < 45) ? CMD_INSERT : (r < 75) ? CMD_SEARCH :
                  (r < 97) ? CMD_REMOVE : CMD_NONE;
            send_command(cmd, pick_key());
            if (cmd == CMD_NONE)
                i--;
        end
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        command = CMD_SEARCH;
        key = 0;
        out_ready = 0;
        cfg_valid = 0;
        cfg_index = REG_TABLE_SIZE;
        cfg_data = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cycle_count = 0;
        repeat (5) @(negedge clk);
        rst_n = 1;

        // Directed part at the reset setting: key extremes and every command.
        send_idle_pct = 31;
        recv_idle_pct = 50;
        send_command(CMD_SEARCH, 31'd0);
        send_command(CMD_INSERT, 31'd0);
        send_command(CMD_INSERT, 31'h7FFF_FFFF);
        send_command(CMD_INSERT, 31'd1024);
        send_command(CMD_INSERT, 31'h7FFF_FFFF);
        send_command(CMD_SEARCH, 31'h7FFF_FFFF);
        send_command(CMD_SEARCH, 31'h5555_5555);
        send_command(CMD_NONE, 31'd7);
        send_command(CMD_REMOVE, 31'd0);
        send_command(CMD_REMOVE, 31'd0);
        send_command(CMD_SEARCH, 31'd1024);
        drain_table;

        // Tiny table with a prime not below the size; fill it past full.
        write_reg(REG_TABLE_SIZE, 11'd2);
        write_reg(REG_PROBE_PRIME, 11'd5);
        send_command(CMD_INSERT, 31'd3);
        send_command(CMD_INSERT, 31'd4);
        send_command(CMD_INSERT, 31'd9);
        send_command(CMD_SEARCH, 31'd9);
        send_command(CMD_REMOVE, 31'd9);
        send_command(CMD_REMOVE, 31'd3);
        drain_table;

        // Size and prime zero, size above the maximum.
        write_reg(REG_TABLE_SIZE, 11'd0);
        write_reg(REG_PROBE_PRIME, 11'd0);
        send_command(CMD_SEARCH, 31'd5);
        send_command(CMD_INSERT, 31'd6);
        drain_table;
        write_reg(REG_TABLE_SIZE, 11'h7FF);
        write_reg(REG_PROBE_PRIME, 11'h3FF);
        send_command(CMD_INSERT, 31'h2AAA_AAAA);
        send_command(CMD_SEARCH, 31'h2AAA_AAAA);
        drain_table;

        // Random phases on small tables so they fill, first idling pattern.
        write_reg(REG_TABLE_SIZE, 11'd13);
        write_reg(REG_PROBE_PRIME, 11'd11);
        key_pool.delete();
        random_phase(130);

        // Receiver holds off long enough that the block stalls its input.
        hold_off = 1;
        hold_cycles = 0;
        fork
            random_phase(4);
            begin
                while (hold_cycles < 3000)
                    @(negedge clk);
                hold_off = 0;
            end
        join
        drain_table;

        send_idle_pct = 50;
        recv_idle_pct = 31;
        write_reg(REG_TABLE_SIZE, 11'd32);
        write_reg(REG_PROBE_PRIME, 11'd31);
        key_pool.delete();
        random_phase(130);
        drain_table;

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_TABLE_SIZE, 11'd7);
        write_reg(REG_PROBE_PRIME, 11'd1);
        key_pool.delete();
        random_phase(110);
        drain_table;
        write_reg(REG_TABLE_SIZE, 11'd1024);
        write_reg(REG_PROBE_PRIME, 11'd1021);
        random_phase(20);

        drain_table;
        $display("Covered search, insert and remove on tables of 1 to 1024 slots,");
        $display("including full tables, ignored commands and long output stalls.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
